@@ rtl/bmp24_to_rgb565_stream_top_defines.svh @@
// Assertion macros for the stream converter RTL.
// BMP_ASSERT: the property must hold at every clock edge out of reset.
// BMP_NEVER: the condition must never be true out of reset.
`ifndef BMP24_TO_RGB565_STREAM_TOP_DEFINES_SVH
`define BMP24_TO_RGB565_STREAM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BMP_ASSERT(lbl, prop, msg)
`define BMP_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/bmp565_pkg.sv @@
package bmp565_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_SKIP     = 2'd1,
    PH_PIXELS   = 2'd2,
    PH_REJECTED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } chan_t;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [15:0] color;
    logic        last;
  } res_t;

  localparam logic [0:0]  REG_DISPLAY_WIDTH  = 1'd0;
  localparam logic [0:0]  REG_DISPLAY_HEIGHT = 1'd1;
  localparam logic [9:0]  DISPLAY_WIDTH_RST  = 10'd130;
  localparam logic [9:0]  DISPLAY_HEIGHT_RST = 10'd131;

  localparam logic [15:0] BMP_SIGNATURE   = 16'h4D42;
  localparam logic [15:0] BMP_BPP_24      = 16'd24;
  localparam logic [5:0]  HEADER_LAST     = 6'd53;
  localparam logic [31:0] MIN_DATA_OFFSET = 32'd54;
  localparam logic [7:0]  RED_MASK        = 8'hF8;
  localparam logic [7:0]  GREEN_MASK      = 8'hFC;

  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // replace byte lane 'lane' of a little-endian word
  function automatic logic [31:0] put_lane(input logic [31:0] f, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = f;
    case (lane)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bmp24_to_rgb565_stream_top.sv @@
// BMP 24-bit to RGB565 stream converter. Feed the file one byte per item on
// in_tdata, with in_tlast on the final byte. Bytes 0..53 are parsed as the
// header; the file is accepted when it is 'BM', 24 bpp, uncompressed, with
// 1..MAX_IMAGE_DIM width and height and a pixel offset of at least 54.
// Pixel data (B,G,R per pixel, rows padded by width mod 4 bytes) comes out
// as RGB565 items in file order, each with its display column and row (file
// rows are stored bottom-up, so file row r lands on row height-1-r), and
// pixels outside display_width x display_height are dropped. The last byte
// of a file adds an end item (tuser accepted/rejected); a header cut short
// counts as rejected. After that end item the parser starts on a new file.
// Each byte is decoded in the cycle it is accepted, so one byte per cycle is
// taken; results go through a four-entry output queue, and in_tready holds
// low only while fewer than two queue slots are free (a byte can yield a
// pixel and an end item). With out_tready held high the sustained rate is
// one byte per clock; a final byte that also completes a pixel yields two
// output items. Write display_width/display_height only while
// the block is idle.
module bmp24_to_rgb565_stream_top
  import bmp565_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  // input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tlast,   // end_of_file
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [9:0] pixel_column, [19:10] pixel_row,
                                  // [35:20] pixel_color, [39:36] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // final_of_run
);

  // counters must hold the image size itself
  localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
  localparam int CMP_W = (DIM_W > 10) ? DIM_W : 10;

  // ---------------------------------------------------------------- registers
  logic [9:0]       disp_w_r, disp_h_r;
  logic [31:0]      pos_r, pos_nxt;
  logic [15:0]      sig_r, sig_nxt;
  logic [31:0]      offset_r, offset_nxt;
  logic [31:0]      img_w_r, img_w_nxt;
  logic [31:0]      img_h_r, img_h_nxt;
  logic [15:0]      bpp_r, bpp_nxt;
  logic [31:0]      comp_r, comp_nxt;
  phase_t           phase_r, phase_nxt;
  chan_t            chan_r, chan_nxt;
  logic [7:0]       blue_r, blue_nxt;
  logic [7:0]       green_r, green_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [1:0]       pad_r, pad_nxt;

  // output queue
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  logic in_acc, out_acc;
  logic header_ok, pix_en, shown;
  logic [9:0]       pix_col, pix_row;
  logic [15:0]      pix_color;
  logic [5:0]       pos6;
  logic [DIM_W-1:0] drow, col_inc;
  logic [CMP_W-1:0] col_cmp, drow_cmp;
  res_t             ent0, ent1;
  logic [1:0]       push_n;

  assign in_tready = (cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign in_acc    = in_tvalid & in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc   = out_tvalid & out_tready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r <= DISPLAY_WIDTH_RST;
      disp_h_r <= DISPLAY_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DISPLAY_WIDTH:  disp_w_r <= cfg_wdata;
        REG_DISPLAY_HEIGHT: disp_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- parser
  assign pos6 = pos_r[5:0];   // header bytes only live at positions below 54

  assign header_ok = (sig_r == BMP_SIGNATURE) && (bpp_r == BMP_BPP_24) && (comp_r == '0) &&
                     (img_w_r >= 32'd1) && (img_w_r <= 32'(MAX_IMAGE_DIM)) &&
                     (img_h_r >= 32'd1) && (img_h_r <= 32'(MAX_IMAGE_DIM)) &&
                     (offset_r >= MIN_DATA_OFFSET);

  assign drow    = img_h_r[DIM_W-1:0] - DIM_W'(1) - row_r;
  assign col_inc = col_r + DIM_W'(1);

  // position compared against the 10-bit display size
  assign col_cmp  = CMP_W'(col_r);
  assign drow_cmp = CMP_W'(drow);

  // next-state logic for one accepted byte
  always_comb begin
    pos_nxt    = pos_r;
    sig_nxt    = sig_r;
    offset_nxt = offset_r;
    img_w_nxt  = img_w_r;
    img_h_nxt  = img_h_r;
    bpp_nxt    = bpp_r;
    comp_nxt   = comp_r;
    phase_nxt  = phase_r;
    chan_nxt   = chan_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pad_nxt    = pad_r;
    pix_en     = 1'b0;
    shown      = 1'b0;
    pix_col    = '0;
    pix_row    = '0;
    pix_color  = '0;

    if (in_acc) begin
      case (phase_r)
        PH_HEADER: begin
          // capture little-endian header fields
          case (pos6) inside
            [6'd0:6'd1]:   sig_nxt = pos6[0] ? {in_tdata, sig_r[7:0]} : {sig_r[15:8], in_tdata};
            [6'd10:6'd13]: offset_nxt = put_lane(offset_r, pos6[1:0] - 2'd2, in_tdata);
            [6'd18:6'd21]: img_w_nxt = put_lane(img_w_r, pos6[1:0] - 2'd2, in_tdata);
            [6'd22:6'd25]: img_h_nxt = put_lane(img_h_r, pos6[1:0] - 2'd2, in_tdata);
            [6'd28:6'd29]: bpp_nxt = pos6[0] ? {in_tdata, bpp_r[7:0]} : {bpp_r[15:8], in_tdata};
            [6'd30:6'd33]: comp_nxt = put_lane(comp_r, pos6[1:0] - 2'd2, in_tdata);
            default: ;
          endcase
        end
        PH_SKIP: begin
          if (pos_r >= offset_r) begin
            phase_nxt = PH_PIXELS;
            pix_en    = 1'b1;
          end
        end
        PH_PIXELS: pix_en = 1'b1;
        default: ;
      endcase

      // the whole header is in: pos 53 uses the fields captured so far
      if (phase_r == PH_HEADER && pos_r == 32'(HEADER_LAST))
        phase_nxt = header_ok ? PH_SKIP : PH_REJECTED;

      if (pix_en && (32'(row_r) < img_h_r)) begin
        if (pad_r != 2'd0) begin
          // drop row padding
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            col_nxt = '0;
            row_nxt = row_r + DIM_W'(1);
          end
        end else begin
          case (chan_r)
            CH_BLUE: begin
              blue_nxt = in_tdata;
              chan_nxt = CH_GREEN;
            end
            CH_GREEN: begin
              green_nxt = in_tdata;
              chan_nxt  = CH_RED;
            end
            default: begin
              chan_nxt  = CH_BLUE;
              shown     = (col_cmp < CMP_W'(disp_w_r)) &&
                          (drow_cmp < CMP_W'(disp_h_r));
              pix_col   = col_cmp[9:0];
              pix_row   = drow_cmp[9:0];
              pix_color = {in_tdata[7:3] & RED_MASK[7:3], green_r[7:2] & GREEN_MASK[7:2],
                           blue_r[7:3]};
              col_nxt   = col_inc;
              if (col_inc >= img_w_r[DIM_W-1:0]) begin
                pad_nxt = img_w_r[1:0];
                if (img_w_r[1:0] == 2'd0) begin
                  col_nxt = '0;
                  row_nxt = row_r + DIM_W'(1);
                end
              end
            end
          endcase
        end
      end

      if (pos_r != '1)
        pos_nxt = pos_r + 32'd1;

      // end of file: restart the parser for the next file
      if (in_tlast) begin
        pos_nxt    = '0;
        sig_nxt    = '0;
        offset_nxt = '0;
        img_w_nxt  = '0;
        img_h_nxt  = '0;
        bpp_nxt    = '0;
        comp_nxt   = '0;
        phase_nxt  = PH_HEADER;
        chan_nxt   = CH_BLUE;
        blue_nxt   = '0;
        green_nxt  = '0;
        col_nxt    = '0;
        row_nxt    = '0;
        pad_nxt    = '0;
      end
    end
  end

  // result items produced by this byte
  always_comb begin
    logic accepted;
    accepted = 1'b0;
    ent0     = '0;
    ent1     = '0;
    push_n   = 2'd0;
    // phase after this byte, before the end-of-file restart
    if (phase_r == PH_SKIP || phase_r == PH_PIXELS)
      accepted = 1'b1;
    else if (phase_r == PH_HEADER && pos_r == 32'(HEADER_LAST) && header_ok)
      accepted = 1'b1;

    ent1.kind = accepted ? KIND_ACCEPT : KIND_REJECT;
    ent1.last = 1'b1;

    if (in_acc) begin
      if (shown) begin
        ent0.kind  = KIND_PIXEL;
        ent0.col   = pix_col;
        ent0.row   = pix_row;
        ent0.color = pix_color;
        ent0.last  = !in_tlast;
        push_n     = in_tlast ? 2'd2 : 2'd1;
      end else if (in_tlast) begin
        ent0   = ent1;
        push_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sig_r    <= '0;
      offset_r <= '0;
      img_w_r  <= '0;
      img_h_r  <= '0;
      bpp_r    <= '0;
      comp_r   <= '0;
      phase_r  <= PH_HEADER;
      chan_r   <= CH_BLUE;
      blue_r   <= '0;
      green_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      pad_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      sig_r    <= sig_nxt;
      offset_r <= offset_nxt;
      img_w_r  <= img_w_nxt;
      img_h_r  <= img_h_nxt;
      bpp_r    <= bpp_nxt;
      comp_r   <= comp_nxt;
      phase_r  <= phase_nxt;
      chan_r   <= chan_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pad_r    <= pad_nxt;
    end
  end

  // ---------------------------------------------------------------- output queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0)
      fifo_r[wr_ptr_r] <= ent0;
    if (push_n == 2'd2)
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= ent1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_n);
      if (out_acc)
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_r + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(out_acc);
    end
  end

  assign out_tdata = {4'd0, fifo_r[rd_ptr_r].color, fifo_r[rd_ptr_r].row,
                      fifo_r[rd_ptr_r].col};
  assign out_tuser = fifo_r[rd_ptr_r].kind;
  assign out_tlast = fifo_r[rd_ptr_r].last;

  // ---------------------------------------------------------------- checks
`include "bmp24_to_rgb565_stream_top_defines.svh"

  `BMP_NEVER(a_fifo_bound, cnt_r > (FIFO_AW + 1)'(FIFO_DEPTH), "output queue overflow")
  `BMP_NEVER(a_chan_code, chan_r > CH_RED, "bad channel index")
  `BMP_ASSERT(a_eof_restart, in_acc && in_tlast |=> phase_r == PH_HEADER && pos_r == '0, "no restart after end of file")
  `BMP_ASSERT(a_pix_dims, phase_r == PH_PIXELS |-> img_w_r >= 32'd1 && img_w_r <= 32'(MAX_IMAGE_DIM), "pixel phase with bad width")

endmodule

@@ test/rgb565_result_check.sv @@
module rgb565_result_check
  import bmp565_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          items_due,
  output int          pixels_seen,
  output int          accepts_seen,
  output int          rejects_seen
);

  // display size as last written
  logic [9:0]  disp_w;
  logic [9:0]  disp_h;

  // parser state of the file being decoded
  logic [31:0] byte_pos;
  logic [15:0] signature;
  logic [31:0] data_offset;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [15:0] bpp;
  logic [31:0] compression;
  phase_t      phase;
  chan_t       chan;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [31:0] col_cnt;
  logic [31:0] row_cnt;
  logic [1:0]  pad_cnt;

  res_t        decoded_items[$];
  int          checked;

  task automatic clear_stream();
    byte_pos    = '0;
    signature   = '0;
    data_offset = '0;
    img_w       = '0;
    img_h       = '0;
    bpp         = '0;
    compression = '0;
    phase       = PH_HEADER;
    chan        = CH_BLUE;
    blue        = '0;
    green       = '0;
    col_cnt     = '0;
    row_cnt     = '0;
    pad_cnt     = '0;
  endtask

  // all four-byte fields start at an offset of 2 mod 4
  task automatic capture_header(input logic [31:0] pos, input logic [7:0] b);
    logic [1:0] lane;
    lane = pos[1:0] - 2'd2;
    if (pos <= 1) signature[8*pos[0] +: 8] = b;
    else if (pos >= 10 && pos <= 13) data_offset[8*lane +: 8] = b;
    else if (pos >= 18 && pos <= 21) img_w[8*lane +: 8] = b;
    else if (pos >= 22 && pos <= 25) img_h[8*lane +: 8] = b;
    else if (pos >= 28 && pos <= 29) bpp[8*pos[0] +: 8] = b;
    else if (pos >= 30 && pos <= 33) compression[8*lane +: 8] = b;
  endtask

  function automatic bit header_ok();
    return signature == BMP_SIGNATURE && bpp == BMP_BPP_24 && compression == 32'd0 &&
           img_w >= 1 && img_w <= MAX_IMAGE_DIM &&
           img_h >= 1 && img_h <= MAX_IMAGE_DIM &&
           data_offset >= MIN_DATA_OFFSET;
  endfunction

  task automatic next_row();
    col_cnt = '0;
    row_cnt++;
  endtask

  task automatic pixel_byte(input logic [7:0] b, output bit shown, output res_t px);
    logic [31:0] drow;
    shown = 1'b0;
    px    = '0;
    if (row_cnt < img_h) begin
      if (pad_cnt != 0) begin
        pad_cnt--;
        if (pad_cnt == 0) next_row();
      end else begin
        case (chan)
          CH_BLUE: begin
            blue = b;
            chan = CH_GREEN;
          end
          CH_GREEN: begin
            green = b;
            chan  = CH_RED;
          end
          default: begin
            // file rows are stored bottom-up
            drow = img_h - 1 - row_cnt;
            chan = CH_BLUE;
            if (col_cnt < disp_w && drow < disp_h) begin
              px.kind  = KIND_PIXEL;
              px.col   = col_cnt[9:0];
              px.row   = drow[9:0];
              px.color = {b & RED_MASK, 8'h00} | {5'b0, green & GREEN_MASK, 3'b0} |
                         {11'b0, blue[7:3]};
              shown    = 1'b1;
            end
            col_cnt++;
            if (col_cnt >= img_w) begin
              pad_cnt = img_w[1:0];
              if (pad_cnt == 0) next_row();
            end
          end
        endcase
      end
    end
  endtask

  task automatic decode_file_byte(input logic [7:0] b, input logic eof);
    logic [31:0] pos;
    bit          shown;
    res_t        px;
    res_t        fin;
    pos   = byte_pos;
    shown = 1'b0;
    px    = '0;
    case (phase)
      PH_HEADER: begin
        capture_header(pos, b);
        if (pos == HEADER_LAST) phase = header_ok() ? PH_SKIP : PH_REJECTED;
      end
      PH_SKIP: begin
        if (pos >= data_offset) begin
          phase = PH_PIXELS;
          pixel_byte(b, shown, px);
        end
      end
      PH_PIXELS: pixel_byte(b, shown, px);
      default: ;
    endcase
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    if (shown) begin
      px.last = !eof;
      decoded_items.push_back(px);
    end
    if (eof) begin
      fin      = '0;
      fin.kind = (phase == PH_SKIP || phase == PH_PIXELS) ? KIND_ACCEPT : KIND_REJECT;
      fin.last = 1'b1;
      decoded_items.push_back(fin);
      clear_stream();
    end
  endtask

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      disp_w       = DISPLAY_WIDTH_RST;
      disp_h       = DISPLAY_HEIGHT_RST;
      fail_count   = 0;
      pixels_seen  = 0;
      accepts_seen = 0;
      rejects_seen = 0;
      checked      = 0;
      clear_stream();
      decoded_items.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DISPLAY_WIDTH:  disp_w = cfg_wdata;
          REG_DISPLAY_HEIGHT: disp_h = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) decode_file_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        checked++;
        if (decoded_items.size() == 0) begin
          report($sformatf("result %0d arrived with nothing due: kind %0d tdata %h last %b",
                           checked, out_tuser, out_tdata, out_tlast));
        end else begin
          want = decoded_items.pop_front();
          if (out_tuser !== want.kind || out_tdata[9:0] !== want.col ||
              out_tdata[19:10] !== want.row || out_tdata[35:20] !== want.color ||
              out_tdata[39:36] !== 4'b0 || out_tlast !== want.last) begin
            report($sformatf({"result %0d: expected kind %0d col %0d row %0d color %h ",
                              "last %b pad 0, got kind %0d col %0d row %0d color %h ",
                              "last %b pad %h"},
                             checked, want.kind, want.col, want.row, want.color, want.last,
                             out_tuser, out_tdata[9:0], out_tdata[19:10], out_tdata[35:20],
                             out_tlast, out_tdata[39:36]));
          end
          case (want.kind)
            KIND_PIXEL:  pixels_seen++;
            KIND_ACCEPT: accepts_seen++;
            default:     rejects_seen++;
          endcase
        end
      end
    end
    items_due = decoded_items.size();
  end

endmodule

@@ test/bmp24_to_rgb565_stream_top_test.sv @@
module bmp24_to_rgb565_stream_top_test;
  import bmp565_pkg::*;

  localparam int MAX_DIM         = 4096;
  localparam int LONG_HOLD       = 300;   // receiver hold-off that fills the output queue
  localparam int STALL_LIMIT     = 4000;  // cycles without any item moving
  localparam int DRAIN_CYCLES    = 8;     // output queue depth plus margin
  localparam int BYTES_PER_PHASE = 80;

  // ways to break an otherwise good header
  typedef enum int {
    BAD_SIGNATURE,
    BAD_BPP,
    BAD_COMPRESSION,
    ZERO_WIDTH,
    OVERSIZE_WIDTH,
    ZERO_HEIGHT,
    OVERSIZE_HEIGHT,
    LOW_OFFSET
  } header_fault_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [9:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int items_due;
  int pixels_seen;
  int accepts_seen;
  int rejects_seen;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int quiet_cycles;

  // bytes of the file being sent, header first
  logic [7:0] file_buf[$];

  bmp24_to_rgb565_stream_top #(
    .MAX_IMAGE_DIM(MAX_DIM)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  rgb565_result_check #(
    .MAX_IMAGE_DIM(MAX_DIM)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .items_due   (items_due),
    .pixels_seen (pixels_seen),
    .accepts_seen(accepts_seen),
    .rejects_seen(rejects_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: stall at the phase's rate; on request hold off for a long
  // stretch while the sender keeps offering bytes.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        hold_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run once no item has moved on either side for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles, %0d results still due",
             STALL_LIMIT, items_due);
    $display("status: fail");
    $finish;
  end

  // Offer one byte, idling first at the phase's rate; return at the edge
  // that accepts it. tready is stable at the falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  // Send the first n bytes of the buffer, marking the n-th as end of file.
  task automatic send_file(input int n);
    for (int i = 0; i < n; i++) send_byte(file_buf[i], i == n - 1);
    files_sent++;
  endtask

  task automatic set_le(input int pos, input logic [31:0] value, input int nbytes);
    for (int k = 0; k < nbytes; k++) file_buf[pos + k] = value[8*k +: 8];
  endtask

  // Random header plus body; the checked fields overwritten with the arguments.
  task automatic build_file(input logic [15:0] sig, input logic [31:0] offset,
                            input logic [31:0] w, input logic [31:0] h,
                            input logic [15:0] bits, input logic [31:0] comp, input int body);
    file_buf.delete();
    repeat (54 + body) file_buf.push_back(8'($urandom));
    set_le(0, sig, 2);
    set_le(10, offset, 4);
    set_le(18, w, 4);
    set_le(22, h, 4);
    set_le(28, bits, 2);
    set_le(30, comp, 4);
  endtask

  // bytes after the header up to the end of the pixel data
  function automatic int pixel_body(input int offset, input int w, input int h);
    return offset - 54 + h * (3 * w + w % 4);
  endfunction

  task automatic good_file(input int offset, input int w, input int h, input int body);
    build_file(BMP_SIGNATURE, offset, w, h, BMP_BPP_24, 32'd0, body);
  endtask

  // A small image with one header field made invalid, then a few data bytes.
  task automatic send_faulty(input header_fault_t fault);
    logic [15:0] sig;
    logic [15:0] bits;
    logic [31:0] comp;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] offset;
    sig    = BMP_SIGNATURE;
    bits   = BMP_BPP_24;
    comp   = '0;
    w      = $urandom_range(1, 7);
    h      = $urandom_range(1, 5);
    offset = 54;
    case (fault)
      BAD_SIGNATURE:   sig    = BMP_SIGNATURE ^ 16'($urandom_range(1, 16'hFFFF));
      BAD_BPP:         bits   = BMP_BPP_24 ^ 16'($urandom_range(1, 16'hFFFF));
      BAD_COMPRESSION: comp   = $urandom_range(1, 32'hFFFF_FFFF);
      ZERO_WIDTH:      w      = '0;
      OVERSIZE_WIDTH:  w      = $urandom_range(MAX_DIM + 1, 32'hFFFF_FFFF);
      ZERO_HEIGHT:     h      = '0;
      OVERSIZE_HEIGHT: h      = $urandom_range(MAX_DIM + 1, 32'hFFFF_FFFF);
      default:         offset = $urandom_range(0, 53);
    endcase
    build_file(sig, offset, w, h, bits, comp, $urandom_range(0, 12));
    send_file(file_buf.size());
  endtask

  // Mostly well-formed small images with random pixels; the rest broken
  // headers, headers cut short and plain noise.
  task automatic random_file();
    int pick;
    int w;
    int h;
    int offset;
    int body;
    int total;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // now and then a row wider than the default display, to clip columns
      w      = ($urandom_range(29) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 7);
      h      = (w > 100) ? 1 : $urandom_range(1, 5);
      offset = ($urandom_range(3) == 0) ? 54 + $urandom_range(1, 6) : 54;
      body   = pixel_body(offset, w, h);
      if ($urandom_range(4) == 0) body += $urandom_range(1, 4);
      good_file(offset, w, h, body);
      total = file_buf.size();
      // cut short anywhere from the end of the header on
      if ($urandom_range(6) == 0) total = $urandom_range(54, total);
      send_file(total);
    end else if (pick < 85) begin
      send_faulty(header_fault_t'($urandom_range(LOW_OFFSET)));
    end else if (pick < 95) begin
      good_file(54, $urandom_range(1, 7), $urandom_range(1, 5), 0);
      send_file($urandom_range(1, 53));
    end else begin
      file_buf.delete();
      repeat (54 + $urandom_range(0, 30)) file_buf.push_back(8'($urandom));
      send_file(file_buf.size());
    end
  endtask

  // Drop valid, wait until every result has come out, then let the block settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (items_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_display(input logic [9:0] w, input logic [9:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DISPLAY_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_DISPLAY_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files at the reset display size, no idling.
    // File of a single byte: header cut short at once.
    good_file(54, 1, 1, 4);
    send_file(1);
    // 1x1 image, end of file on its pad byte
    good_file(54, 1, 1, pixel_body(54, 1, 1));
    send_file(file_buf.size());
    // 4x1 image, no pad: the last byte yields a pixel and the end item
    good_file(54, 4, 1, pixel_body(54, 4, 1));
    send_file(file_buf.size());
    // gap before the pixel data and trailing bytes after it
    good_file(60, 2, 2, pixel_body(60, 2, 2) + 3);
    send_file(file_buf.size());
    // end of file on the last header byte still accepts
    good_file(54, 3, 3, 0);
    send_file(54);
    // every way to reject a header
    for (int f = BAD_SIGNATURE; f <= LOW_OFFSET; f++) send_faulty(header_fault_t'(f));
    // largest accepted sizes, data cut short
    good_file(54, MAX_DIM, 2, 18);
    send_file(file_buf.size());
    good_file(54, 1, MAX_DIM, 12);
    send_file(file_buf.size());

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        1: set_display(10'd1, 10'd1);
        2: set_display(10'd1023, 10'd1023);
        3: set_display(10'($urandom_range(2, 8)), 10'($urandom_range(1, 6)));
        default: ;
      endcase
      idle_pct  = (p == 1) ? 75 : (p == 3) ? 36 : 0;
      stall_pct <= (p == 2) ? 75 : (p == 3) ? 36 : 0;

      if (p == 0) begin
        // Hold the receiver off across a pixel-rich file so the queue fills
        // and the input stalls.
        hold_asks <= hold_asks + 1;
        good_file(54, 8, 6, pixel_body(54, 8, 6));
        send_file(file_buf.size());
      end
      if (p == 2) begin
        // reach the last display row
        good_file(54, 1, 1023, 8 + 3);
        send_file(file_buf.size());
      end

      start = bytes_sent;
      while (bytes_sent - start < BYTES_PER_PHASE) random_file();
    end

    wait_drained();
    repeat (16) @(posedge clk);

    $display("covered %0d bytes in %0d files over four idle/stall phases and display sizes",
             bytes_sent, files_sent);
    $display("130x131, 1x1, 1023x1023 and a small one: %0d pixels, %0d accepted, %0d rejected",
             pixels_seen, accepts_seen, rejects_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
